// ----- hw/rtl/keyed_slot_table_top_macros.svh -----
// ----------------------------------------------------------------------------
// keyed_slot_table_top_macros
// Assertion macros shared by the keyed slot table checker.
// ----------------------------------------------------------------------------
`ifndef KEYED_SLOT_TABLE_TOP_MACROS_SVH
`define KEYED_SLOT_TABLE_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define KST_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/kst_pkg.sv -----
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants of the keyed slot table.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		CMD_INSERT     = 2'd0,
		CMD_FIND       = 2'd1,
		CMD_ERASE_KEY  = 2'd2,
		CMD_ERASE_SLOT = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_PRESENT  = 3'd1,
		ST_CONFLICT = 3'd2,
		ST_FULL     = 3'd3,
		ST_INVALID  = 3'd4,
		ST_FOUND    = 3'd5,
		ST_NOTFOUND = 3'd6,
		ST_ERASED   = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_KSCAN,
		S_FSCAN,
		S_SREAD,
		S_DONE
	} state_t;

	typedef struct packed {
		cmd_t               command;
		logic signed [31:0] task_key;
		logic signed [31:0] group_id;
		logic [7:0]         slot_index;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [5:0]  match_slot;
		logic [30:0] match_group;
		logic [6:0]  entry_count;
		logic        table_full;
		logic [31:0] change_count;
	} rsp_t;

	typedef struct packed {
		logic [30:0] key;
		logic [30:0] grp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic valid;
		rsp_t item;
	} result_t;

endpackage

// ----- hw/rtl/keyed_slot_table_top.sv -----
// ----------------------------------------------------------------------------
// keyed_slot_table_top
// Fixed-capacity keyed slot table with insert, find and erase commands.
// ----------------------------------------------------------------------------
// One command is processed at a time; each yields one response item. Invalid
// arguments and erase-by-slot of a free slot go straight to the response; erase
// by slot reads the entry RAM once first. Key commands scan the entry RAM one
// slot per cycle through its single read port, up to the last slot when the key
// is absent. An insert of a new key into a table that is not full then scans the
// occupancy bits circularly from the free hint, one slot per cycle.
// The response sits in an output register, so the next command is taken while
// a response still waits on rsp_stall.
module keyed_slot_table_top import kst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	result_t res;
	logic    load;

	kst_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.res      (res),
		.res_take (load)
	);

	assign load = res.valid && (!rsp_valid || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (load) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp <= res.item;
		end
	end

endmodule

// ----- hw/rtl/kst_ram.sv -----
// ----------------------------------------------------------------------------
// kst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/kst_engine.sv -----
// ----------------------------------------------------------------------------
// kst_engine
// Command sequencer: key scan over the entry RAM, free-slot scan over the
// occupancy bits, and the table bookkeeping.
// ----------------------------------------------------------------------------
module kst_engine import kst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  req_t    req,
	output result_t res,
	input  logic    res_take
);

	state_t state_q, state_d;

	req_t              req_q;
	logic [SLOT_W:0]   scan_q;
	logic              cmp_vld_s1;
	logic [SLOT_W-1:0] cmp_idx_s1;
	logic [SLOT_W-1:0] pos_q;
	logic [CAPACITY-1:0] used_q;
	logic [CNT_W-1:0]  count_q;
	logic [SLOT_W-1:0] hint_q;
	logic [31:0]       chg_q;
	status_t           status_q;
	logic [SLOT_W-1:0] mslot_q;
	logic [30:0]       mgrp_q;

	logic              accept;
	logic              hit;
	logic              kmiss;
	logic              issue;
	logic              free_hit;
	logic              is_full;
	logic              pre_done;
	status_t           pre_status;
	logic              slot_ok;
	logic [SLOT_W-1:0] sidx;
	logic [SLOT_W-1:0] pos_next;

	logic              ram_we;
	logic              ram_re;
	logic [SLOT_W-1:0] ram_raddr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;

	kst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pos_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// events
	always_comb begin
		sidx     = req.slot_index[SLOT_W-1:0];
		slot_ok  = (int'(req.slot_index) < CAPACITY) && used_q[sidx];
		accept   = (state_q == S_IDLE) && req_valid;
		hit      = (state_q == S_KSCAN) && cmp_vld_s1 && used_q[cmp_idx_s1]
			&& (ram_rdata.key == req_q.task_key[30:0]);
		kmiss    = (state_q == S_KSCAN) && cmp_vld_s1 && !hit
			&& (cmp_idx_s1 == SLOT_W'(CAPACITY - 1));
		issue    = (state_q == S_KSCAN) && (scan_q < (SLOT_W+1)'(CAPACITY));
		free_hit = (state_q == S_FSCAN) && !used_q[pos_q];
		is_full  = (int'(count_q) >= CAPACITY);
		pos_next = (pos_q == SLOT_W'(CAPACITY - 1)) ? '0 : pos_q + 1'b1;

		pre_done   = 1'b0;
		pre_status = ST_NOTFOUND;
		unique case (req.command)
			CMD_INSERT: begin
				if (req.task_key <= 0 || req.group_id <= 0) begin
					pre_done   = 1'b1;
					pre_status = ST_INVALID;
				end
			end
			CMD_FIND, CMD_ERASE_KEY: begin
				pre_done = (req.task_key <= 0);
			end
			CMD_ERASE_SLOT: begin
				pre_done = !slot_ok;
			end
			default: begin
				pre_done = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (pre_done) begin
						state_d = S_DONE;
					end else if (req.command == CMD_ERASE_SLOT) begin
						state_d = S_SREAD;
					end else begin
						state_d = S_KSCAN;
					end
				end
			end
			S_KSCAN: begin
				if (hit) begin
					state_d = S_DONE;
				end else if (kmiss) begin
					if (req_q.command == CMD_INSERT && !is_full) begin
						state_d = S_FSCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_FSCAN: begin
				if (free_hit) begin
					state_d = S_DONE;
				end
			end
			S_SREAD: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_stall     = (state_q != S_IDLE);
		ram_we        = free_hit;
		ram_wdata.key = req_q.task_key[30:0];
		ram_wdata.grp = req_q.group_id[30:0];
		ram_re        = accept || issue;
		ram_raddr     = (state_q == S_IDLE) ? sidx : scan_q[SLOT_W-1:0];

		res.valid             = (state_q == S_DONE);
		res.item.status       = status_q;
		res.item.match_slot   = 6'(mslot_q);
		res.item.match_group  = mgrp_q;
		res.item.entry_count  = 7'(count_q);
		res.item.table_full   = is_full;
		res.item.change_count = chg_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmp_vld_s1 <= 1'b0;
			used_q     <= '0;
			count_q    <= '0;
			hint_q     <= '0;
			chg_q      <= '0;
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= issue && !hit;
			if (accept) begin
				status_q <= pre_status;
				mslot_q  <= '0;
				mgrp_q   <= '0;
			end
			if (hit) begin
				mslot_q <= cmp_idx_s1;
				mgrp_q  <= ram_rdata.grp;
				unique case (req_q.command)
					CMD_INSERT: begin
						status_q <= (ram_rdata.grp == req_q.group_id[30:0]) ?
							ST_PRESENT : ST_CONFLICT;
					end
					CMD_FIND: begin
						status_q <= ST_FOUND;
					end
					default: begin
						status_q           <= ST_ERASED;
						used_q[cmp_idx_s1] <= 1'b0;
						count_q            <= count_q - 1'b1;
						chg_q              <= chg_q + 1'b1;
						hint_q             <= cmp_idx_s1;
					end
				endcase
			end
			if (kmiss && req_q.command == CMD_INSERT) begin
				status_q <= ST_FULL;
			end
			if (state_q == S_SREAD) begin
				status_q                                <= ST_ERASED;
				mslot_q                                 <= req_q.slot_index[SLOT_W-1:0];
				mgrp_q                                  <= ram_rdata.grp;
				used_q[req_q.slot_index[SLOT_W-1:0]]    <= 1'b0;
				count_q                                 <= count_q - 1'b1;
				chg_q                                   <= chg_q + 1'b1;
				hint_q                                  <= req_q.slot_index[SLOT_W-1:0];
			end
			if (free_hit) begin
				status_q      <= ST_INSERTED;
				mslot_q       <= pos_q;
				mgrp_q        <= req_q.group_id[30:0];
				used_q[pos_q] <= 1'b1;
				count_q       <= count_q + 1'b1;
				chg_q         <= chg_q + 1'b1;
				hint_q        <= pos_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req;
			scan_q <= '0;
		end
		if (issue) begin
			scan_q     <= scan_q + 1'b1;
			cmp_idx_s1 <= scan_q[SLOT_W-1:0];
		end
		if (kmiss) begin
			pos_q <= hint_q;
		end else if (state_q == S_FSCAN && !free_hit) begin
			pos_q <= pos_next;
		end
	end

endmodule

// ----- hw/rtl/keyed_slot_table_checker.sv -----
// ----------------------------------------------------------------------------
// keyed_slot_table_checker
// Port-level checks of the keyed slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyed_slot_table_top_macros.svh"

module keyed_slot_table_checker import kst_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	`KST_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp changed while stalled")
	`KST_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "took a second item while busy")
	`KST_ASSERT_NOW(a_no_match_zero, rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_INVALID || rsp.status == ST_NOTFOUND), rsp.match_slot == '0 && rsp.match_group == '0, "match fields not zero")
	`KST_ASSERT_NOW(a_full_flag, rsp_valid && rsp.status == ST_FULL, rsp.table_full, "full status without full flag")

endmodule

bind keyed_slot_table_top keyed_slot_table_checker u_checker (.*);

// ----- dv/keyed_slot_table_top_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table_top_checker
// Watches both channels of the keyed slot table, keeps its own copy of the
// table, predicts each response item and compares it field by field.
// ----------------------------------------------------------------------------
module keyed_slot_table_top_checker import kst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fail_count,
	output int   pending
);

	logic        used_q [CAPACITY];
	logic [30:0] key_q  [CAPACITY];
	logic [30:0] grp_q  [CAPACITY];
	int unsigned count_q;
	int unsigned hint_q;
	logic [31:0] changes_q;

	rsp_t pending_rsps [$];

	function automatic int find_key(logic [30:0] k);
		for (int s = 0; s < CAPACITY; s++)
			if (used_q[s] && key_q[s] == k)
				return s;
		return CAPACITY;
	endfunction

	function automatic void clear_entry(int s);
		used_q[s] = 1'b0;
		key_q[s]  = '0;
		grp_q[s]  = '0;
		if (count_q > 0)
			count_q--;
		changes_q++;
		hint_q = s;
	endfunction

	function automatic rsp_t apply_table_op(req_t item);
		rsp_t r;
		int   s;
		int   t;
		int   start;
		bit   placed;
		r        = '0;
		r.status = ST_NOTFOUND;
		case (item.command)
			CMD_INSERT: begin
				if (item.task_key <= 0 || item.group_id <= 0) begin
					r.status = ST_INVALID;
				end else begin
					s = find_key(item.task_key[30:0]);
					if (s < CAPACITY) begin
						r.match_slot  = s[5:0];
						r.match_group = grp_q[s];
						r.status = (grp_q[s] == item.group_id[30:0]) ? ST_PRESENT : ST_CONFLICT;
					end else begin
						r.status = ST_FULL;
						if (count_q < CAPACITY) begin
							start  = (hint_q < CAPACITY) ? hint_q : 0;
							placed = 1'b0;
							for (int off = 0; off < CAPACITY && !placed; off++) begin
								t = (start + off) % CAPACITY;
								if (!used_q[t]) begin
									used_q[t] = 1'b1;
									key_q[t]  = item.task_key[30:0];
									grp_q[t]  = item.group_id[30:0];
									count_q++;
									changes_q++;
									hint_q        = (t + 1 >= CAPACITY) ? 0 : t + 1;
									r.match_slot  = t[5:0];
									r.match_group = item.group_id[30:0];
									r.status      = ST_INSERTED;
									placed        = 1'b1;
								end
							end
						end
					end
				end
			end
			CMD_FIND, CMD_ERASE_KEY: begin
				s = (item.task_key > 0) ? find_key(item.task_key[30:0]) : CAPACITY;
				if (s < CAPACITY) begin
					r.match_slot  = s[5:0];
					r.match_group = grp_q[s];
					if (item.command == CMD_FIND) begin
						r.status = ST_FOUND;
					end else begin
						clear_entry(s);
						r.status = ST_ERASED;
					end
				end
			end
			default: begin
				if (item.slot_index < CAPACITY && used_q[item.slot_index]) begin
					r.match_slot  = item.slot_index[5:0];
					r.match_group = grp_q[item.slot_index];
					clear_entry(item.slot_index);
					r.status = ST_ERASED;
				end
			end
		endcase
		r.entry_count  = count_q[6:0];
		r.table_full   = (count_q >= CAPACITY);
		r.change_count = changes_q;
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t exp_rsp;
		if (!arst_n) begin
			for (int s = 0; s < CAPACITY; s++) begin
				used_q[s] = 1'b0;
				key_q[s]  = '0;
				grp_q[s]  = '0;
			end
			count_q    = 0;
			hint_q     = 0;
			changes_q  = '0;
			fail_count = 0;
			pending_rsps.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsps.size() == 0) begin
					$error("response item with none expected");
					fail_count++;
				end else begin
					exp_rsp = pending_rsps.pop_front();
					check_field("status", exp_rsp.status, rsp.status);
					check_field("match_slot", exp_rsp.match_slot, rsp.match_slot);
					check_field("match_group", exp_rsp.match_group, rsp.match_group);
					check_field("entry_count", exp_rsp.entry_count, rsp.entry_count);
					check_field("table_full", exp_rsp.table_full, rsp.table_full);
					check_field("change_count", exp_rsp.change_count, rsp.change_count);
				end
			end
			if (req_valid && !req_stall)
				pending_rsps.push_back(apply_table_op(req));
		end
		pending = pending_rsps.size();
	end

endmodule

// ----- dv/keyed_slot_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_slot_table_top_tb
// Drives the keyed slot table with directed corner cases and then phases of
// random commands biased toward filling or draining the table, with random
// idle bursts on both channels and one long response hold-off.
// ----------------------------------------------------------------------------
module keyed_slot_table_top_tb import kst_pkg::*;;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 600;
	localparam int PHASE_ITEMS    = 170;
	localparam int NUM_PHASES     = 8;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int  fail_count;
	int  pending;
	bit  idling_enabled;
	bit  pressure_on;
	bit  long_hold;
	int  stall_left = 0;
	int  quiet_cycles = 0;

	logic [31:0] recent_keys [16];

	keyed_slot_table_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	keyed_slot_table_top_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idling_enabled && $urandom_range(0, 7) == 0)
			stall_left = $urandom_range(1, 14);
		rsp_stall <= long_hold || (stall_left > 0);
	end

	initial begin
		long_hold = 1'b0;
		wait (pressure_on);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[keyed_slot_table_top] ERROR");
			$finish;
		end
	end

	task automatic send_item(cmd_t c, logic [31:0] k, logic [31:0] g, logic [7:0] s);
		req_t item;
		if (idling_enabled && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item.command    = c;
		item.task_key   = k;
		item.group_id   = g;
		item.slot_index = s;
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic send_random(int insert_pct);
		cmd_t        c;
		logic [31:0] k;
		logic [31:0] g;
		logic [7:0]  s;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < insert_pct)
			c = CMD_INSERT;
		else
			case ($urandom_range(0, 2))
				0:       c = CMD_FIND;
				1:       c = CMD_ERASE_KEY;
				default: c = CMD_ERASE_SLOT;
			endcase
		pick = $urandom_range(0, 19);
		if (pick == 0)
			k = $urandom();
		else if (pick == 1)
			k = -$urandom_range(0, 3);
		else if (pick < 8)
			k = recent_keys[$urandom_range(0, 15)];
		else
			k = $urandom_range(1, 90);
		pick = $urandom_range(0, 11);
		if (pick == 0)
			g = $urandom();
		else if (pick == 1)
			g = -$urandom_range(0, 1);
		else
			g = $urandom_range(1, 3);
		s = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 63));
		if (c == CMD_INSERT && pick > 1)
			recent_keys[$urandom_range(0, 15)] = k;
		send_item(c, k, g, s);
	endtask

	initial begin
		int insert_mix [NUM_PHASES];
		insert_mix     = '{90, 40, 95, 20, 70, 5, 85, 50};
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		pressure_on    = 1'b0;
		idling_enabled = 1'b1;
		for (int i = 0; i < 16; i++)
			recent_keys[i] = 32'($urandom_range(1, 90));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// invalid insert arguments
		send_item(CMD_INSERT, 32'd0, 32'd5, 8'd0);
		send_item(CMD_INSERT, 32'h8000_0000, 32'd5, 8'd0);
		send_item(CMD_INSERT, 32'd7, 32'd0, 8'd0);
		send_item(CMD_INSERT, 32'd7, 32'h8000_0000, 8'd0);
		// extremes, duplicate and conflicting group
		send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0);
		send_item(CMD_INSERT, 32'd1, 32'd1, 8'd0);
		send_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0);
		send_item(CMD_INSERT, 32'd1, 32'd2, 8'd0);
		// lookups
		send_item(CMD_FIND, 32'h7FFF_FFFF, 32'd0, 8'd0);
		send_item(CMD_FIND, 32'd12345, 32'd0, 8'd0);
		send_item(CMD_FIND, 32'd0, 32'd0, 8'd0);
		send_item(CMD_FIND, 32'hFFFF_FFFF, 32'd0, 8'd0);
		// erase by key: absent, invalid, present; freed slot is reused
		send_item(CMD_ERASE_KEY, 32'd99, 32'd0, 8'd0);
		send_item(CMD_ERASE_KEY, -32'sd5, 32'd0, 8'd0);
		send_item(CMD_ERASE_KEY, 32'd1, 32'd0, 8'd0);
		send_item(CMD_INSERT, 32'd42, 32'd3, 8'd0);
		// erase by slot: out of range, free, occupied
		send_item(CMD_ERASE_SLOT, 32'd0, 32'd0, 8'd255);
		send_item(CMD_ERASE_SLOT, 32'd0, 32'd0, 8'd64);
		send_item(CMD_ERASE_SLOT, 32'd0, 32'd0, 8'd63);
		send_item(CMD_ERASE_SLOT, 32'd0, 32'd0, 8'd0);
		send_item(CMD_FIND, 32'h7FFF_FFFF, 32'd0, 8'd0);
		send_item(CMD_INSERT, 32'h5555_5555, 32'h2AAA_AAAA, 8'd0);
		send_item(CMD_ERASE_SLOT, 32'd0, 32'd0, 8'd1);
		send_item(CMD_ERASE_KEY, 32'h5555_5555, 32'd0, 8'd0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			idling_enabled = (p != 4) && (p != NUM_PHASES - 1);
			if (p == 2)
				pressure_on = 1'b1;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random(insert_mix[p]);
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("[keyed_slot_table_top] OK");
		else
			$display("[keyed_slot_table_top] ERROR");
		$finish;
	end

endmodule
